// File: sv/psg_pkg.sv
// Shared types and constants for the prime sieve range gap block.
// No dependencies; every other file of the block depends on this package.
package psg_pkg;

    localparam int MAX_N_DEF = 65536;
    localparam int LIMIT_W   = 16;
    localparam int RANGE_W   = 16;
    localparam int GAP_W     = 17;
    localparam int STATUS_W  = 3;

    localparam logic REQ_BUILD = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_SEVERAL = 3'd0,
        ST_ONE     = 3'd1,
        ST_NONE    = 3'd2,
        ST_BUILT   = 3'd3,
        ST_REJECT  = 3'd4
    } t_status;

    // Decision taken on an incoming item.
    typedef struct packed {
        logic is_build;
        logic reject;
    } t_admit;

endpackage

// File: sv/psg_if.sv
// Handshake channels of the prime sieve range gap block: request, result
// and configuration. Depends on psg_pkg for the field widths.
interface psg_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [psg_pkg::RANGE_W-1:0]   range_low;
    logic [psg_pkg::RANGE_W-1:0]   range_high;

    modport source (output valid, req_type, range_low, range_high, input ready);
    modport sink   (input valid, req_type, range_low, range_high, output ready);
endinterface

interface psg_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [psg_pkg::GAP_W-1:0]     max_gap;
    logic [psg_pkg::STATUS_W-1:0]         status;

    modport source (output valid, max_gap, status, input ready);
    modport sink   (input valid, max_gap, status, output ready);
endinterface

interface psg_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [psg_pkg::LIMIT_W-1:0]   limit;

    modport source (output valid, limit, input ready);
    modport sink   (input valid, limit, output ready);
endinterface

// File: sv/psg_admit.sv
// Classifies an incoming item (build, rejected query, valid query) and
// clamps the limit register to the map size. Depends on psg_pkg.
module psg_admit #(
    parameter int MAX_N = psg_pkg::MAX_N_DEF,
    parameter int AW    = $clog2(MAX_N)
) (
    input  logic                          i_req_type,
    input  logic [psg_pkg::RANGE_W-1:0]   i_range_low,
    input  logic [psg_pkg::RANGE_W-1:0]   i_range_high,
    input  logic [psg_pkg::LIMIT_W-1:0]   i_limit,
    input  logic [AW-1:0]                 i_built_limit,
    input  logic                          i_sieve_ready,
    output psg_pkg::t_admit               o_admit,
    output logic [AW-1:0]                 o_top
);
    import psg_pkg::*;

    always_comb begin
        // A build never covers more than the map holds.
        if (32'(i_limit) > 32'(MAX_N - 1)) begin
            o_top = AW'(MAX_N - 1);
        end else begin
            o_top = AW'(i_limit);
        end

        o_admit.is_build = (i_req_type == REQ_BUILD);
        o_admit.reject   = !i_sieve_ready
                        || (i_range_low > i_range_high)
                        || (i_range_high > i_limit)
                        || (32'(i_range_high) > 32'(i_built_limit));
    end

endmodule

// File: sv/prime_sieve_range_gap.sv
// Prime sieve with range gap queries. A build clears the map up to the
// clamped limit, then tests each number up to sqrt(limit) and marks the
// multiples of each prime found; a query scans map entries from each end,
// one shared map port setting the pace.
// One item at a time; the output register lets the next item enter early.
// Synchronous active-low reset clears control state; the map is not cleared.
module prime_sieve_range_gap #(
    parameter int MAX_N = psg_pkg::MAX_N_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    psg_req_if.sink       i_req,
    psg_rsp_if.source     o_rsp,
    psg_cfg_if.sink       i_cfg
);
    import psg_pkg::*;

    localparam int AW = $clog2(MAX_N);

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_BRD, S_BTST, S_MARK,
        S_QRD1, S_QT1, S_QRD2, S_QT2, S_DONE
    } t_state;

    t_state                 r_state;
    logic [LIMIT_W-1:0]     r_limit;
    logic [AW-1:0]          r_built;
    logic                   r_sieve_ready;
    logic [AW-1:0]          r_top;
    logic [AW-1:0]          r_i;
    logic [AW:0]            r_sq;
    logic [AW:0]            r_j;
    logic [AW-1:0]          r_p;
    logic [AW-1:0]          r_q;
    logic [AW-1:0]          r_hi;
    logic [GAP_W-1:0]       r_res_gap;
    t_status                r_res_status;
    logic                   r_out_valid;
    logic [GAP_W-1:0]       r_out_gap;
    t_status                r_out_status;

    logic                   mem [MAX_N];
    logic                   r_rdata;
    logic [AW-1:0]          w_addr;
    logic                   w_we;
    logic                   w_wdata;
    logic [AW:0]            w_jnext;

    t_admit                 w_admit;
    logic [AW-1:0]          w_top;

    psg_admit #(.MAX_N(MAX_N), .AW(AW)) u_admit (
        .i_req_type    (i_req.req_type),
        .i_range_low   (i_req.range_low),
        .i_range_high  (i_req.range_high),
        .i_limit       (r_limit),
        .i_built_limit (r_built),
        .i_sieve_ready (r_sieve_ready),
        .o_admit       (w_admit),
        .o_top         (w_top)
    );

    assign i_req.ready   = (r_state == S_IDLE);
    assign i_cfg.ready   = 1'b1;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.max_gap = r_out_gap;
    assign o_rsp.status  = r_out_status;

    assign w_jnext = r_j + {1'b0, r_i};

    // Single map port: the sequencer state picks the address.
    always_comb begin
        w_we    = 1'b0;
        w_wdata = 1'b0;
        case (r_state)
            S_CLR: begin
                w_addr  = r_i;
                w_we    = 1'b1;
                w_wdata = (r_i < AW'(2));
            end
            S_BRD:  w_addr = r_i;
            S_MARK: begin
                w_addr  = r_j[AW-1:0];
                w_we    = 1'b1;
                w_wdata = 1'b1;
            end
            S_QRD1: w_addr = r_p;
            S_QRD2: w_addr = r_q;
            default: w_addr = r_i;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_addr] <= w_wdata;
        end
        r_rdata <= mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_limit       <= LIMIT_W'(65535);
            r_built       <= '0;
            r_sieve_ready <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_limit <= i_cfg.limit;
            end
            // In S_DONE the output register is handled by the load below.
            if (o_rsp.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_p  <= AW'(i_req.range_low);
                        r_hi <= AW'(i_req.range_high);
                        if (w_admit.is_build) begin
                            r_top   <= w_top;
                            r_i     <= '0;
                            r_state <= S_CLR;
                        end else if (w_admit.reject) begin
                            r_res_gap    <= '0;
                            r_res_status <= ST_REJECT;
                            r_state      <= S_DONE;
                        end else begin
                            r_state <= S_QRD1;
                        end
                    end
                end
                S_CLR: begin
                    // Zero and one are written as composite during the clear.
                    if (r_i == r_top) begin
                        r_i     <= AW'(2);
                        r_sq    <= (AW + 1)'(4);
                        r_state <= S_BRD;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_BRD: begin
                    // Once i*i passes the top, no further number can strike anything.
                    if (r_sq > {1'b0, r_top}) begin
                        r_built       <= r_top;
                        r_sieve_ready <= 1'b1;
                        r_res_gap     <= '0;
                        r_res_status  <= ST_BUILT;
                        r_state       <= S_DONE;
                    end else begin
                        r_state <= S_BTST;
                    end
                end
                S_BTST: begin
                    if (!r_rdata) begin
                        r_j     <= r_sq;
                        r_state <= S_MARK;
                    end else begin
                        r_sq    <= r_sq + {r_i, 1'b1};
                        r_i     <= r_i + 1'b1;
                        r_state <= S_BRD;
                    end
                end
                S_MARK: begin
                    if (w_jnext > {1'b0, r_top}) begin
                        r_sq    <= r_sq + {r_i, 1'b1};
                        r_i     <= r_i + 1'b1;
                        r_state <= S_BRD;
                    end else begin
                        r_j <= w_jnext;
                    end
                end
                S_QRD1: r_state <= S_QT1;
                S_QT1: begin
                    if (!r_rdata) begin
                        r_q     <= r_hi;
                        r_state <= S_QRD2;
                    end else if (r_p == r_hi) begin
                        r_res_gap    <= '1;
                        r_res_status <= ST_NONE;
                        r_state      <= S_DONE;
                    end else begin
                        r_p     <= r_p + 1'b1;
                        r_state <= S_QRD1;
                    end
                end
                S_QRD2: begin
                    if (r_q == r_p) begin
                        r_res_gap    <= '0;
                        r_res_status <= ST_ONE;
                        r_state      <= S_DONE;
                    end else begin
                        r_state <= S_QT2;
                    end
                end
                S_QT2: begin
                    if (!r_rdata) begin
                        r_res_gap    <= GAP_W'(r_q - r_p);
                        r_res_status <= ST_SEVERAL;
                        r_state      <= S_DONE;
                    end else begin
                        r_q     <= r_q - 1'b1;
                        r_state <= S_QRD2;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_gap    <= r_res_gap;
                        r_out_status <= r_res_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: tb/prime_sieve_range_gap_tb.sv
// Self-checking testbench for prime_sieve_range_gap: a directed table, then
// random build and range query items over several sieve limits.
// Depends on psg_pkg, the psg_*_if channels and the block itself.
module prime_sieve_range_gap_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import psg_pkg::*;

    localparam int MAP_DEPTH   = MAX_N_DEF;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int NUM_PHASES  = 8;
    localparam int NUM_PROBES  = 19;

    typedef struct packed {
        logic signed [GAP_W-1:0] gap;
        t_status                 status;
    } t_outcome;

    typedef struct packed {
        logic               req;
        logic [RANGE_W-1:0] lo;
        logic [RANGE_W-1:0] hi;
        bit                 typed;
        t_outcome           want;
    } t_probe;

    // Rows with typed set carry a result read straight off the sieve; the
    // rest are left to the predictor. The limit is still at its reset value.
    localparam t_probe PROBES [NUM_PROBES] = '{
        '{REQ_QUERY, 16'd0,     16'd10,    1'b1, '{17'sd0,     ST_REJECT}},
        '{REQ_QUERY, 16'd7,     16'd3,     1'b1, '{17'sd0,     ST_REJECT}},
        '{REQ_BUILD, 16'd0,     16'd0,     1'b1, '{17'sd0,     ST_BUILT}},
        '{REQ_QUERY, 16'd0,     16'd0,     1'b1, '{-17'sd1,    ST_NONE}},
        '{REQ_QUERY, 16'd0,     16'd1,     1'b1, '{-17'sd1,    ST_NONE}},
        '{REQ_QUERY, 16'd2,     16'd2,     1'b1, '{17'sd0,     ST_ONE}},
        '{REQ_QUERY, 16'd2,     16'd3,     1'b1, '{17'sd1,     ST_SEVERAL}},
        '{REQ_QUERY, 16'd24,    16'd28,    1'b1, '{-17'sd1,    ST_NONE}},
        '{REQ_QUERY, 16'd89,    16'd97,    1'b1, '{17'sd8,     ST_SEVERAL}},
        '{REQ_QUERY, 16'd90,    16'd96,    1'b1, '{-17'sd1,    ST_NONE}},
        '{REQ_QUERY, 16'd0,     16'd65535, 1'b1, '{17'sd65519, ST_SEVERAL}},
        '{REQ_QUERY, 16'd65521, 16'd65535, 1'b1, '{17'sd0,     ST_ONE}},
        '{REQ_QUERY, 16'd65535, 16'd65535, 1'b1, '{-17'sd1,    ST_NONE}},
        '{REQ_QUERY, 16'd65535, 16'd0,     1'b1, '{17'sd0,     ST_REJECT}},
        '{REQ_QUERY, 16'd32768, 16'd33000, 1'b0, '{17'sd0,     ST_SEVERAL}},
        '{REQ_QUERY, 16'd1000,  16'd2000,  1'b0, '{17'sd0,     ST_SEVERAL}},
        '{REQ_QUERY, 16'd21845, 16'd43690, 1'b0, '{17'sd0,     ST_SEVERAL}},
        '{REQ_QUERY, 16'd43690, 16'd65534, 1'b0, '{17'sd0,     ST_SEVERAL}},
        '{REQ_QUERY, 16'd1,     16'd65535, 1'b0, '{17'sd0,     ST_SEVERAL}}
    };

    logic i_clk;
    logic i_rst_n;

    psg_req_if req_ch ();
    psg_rsp_if rsp_ch ();
    psg_cfg_if cfg_ch ();

    prime_sieve_range_gap uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    // Predictor state: composite flags, last covered limit and the register.
    bit       composite [MAP_DEPTH];
    bit       sieve_built;
    int       sieve_top;
    int       cfg_limit;

    t_outcome pending_outcomes [$];
    int       mismatches;
    int       cycle_count;
    bit       stall_en;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        cycle_count = 0;
        wait (cycle_count >= CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic t_outcome predict_outcome(input logic req, input int lo, input int hi);
        t_outcome res;
        int       top;
        int       i;
        int       j;
        int       p;
        int       q;
        res.gap    = '0;
        res.status = ST_REJECT;
        if (req == REQ_BUILD) begin
            top = (cfg_limit > MAP_DEPTH - 1) ? MAP_DEPTH - 1 : cfg_limit;
            for (i = 0; i <= top; i++)
                composite[i] = 1'b0;
            composite[0] = 1'b1;
            if (top >= 1)
                composite[1] = 1'b1;
            for (i = 2; i * i <= top; i++) begin
                if (!composite[i]) begin
                    for (j = i * i; j <= top; j += i)
                        composite[j] = 1'b1;
                end
            end
            sieve_top   = top;
            sieve_built = 1'b1;
            res.status  = ST_BUILT;
        end else if (!sieve_built || lo > hi || hi > cfg_limit || hi > sieve_top) begin
            res.status = ST_REJECT;
        end else begin
            p = lo;
            while (p <= hi && composite[p])
                p++;
            if (p > hi) begin
                res.gap    = -1;
                res.status = ST_NONE;
            end else begin
                q = hi;
                while (q > p && composite[q])
                    q--;
                if (q == p) begin
                    res.status = ST_ONE;
                end else begin
                    res.gap    = q - p;
                    res.status = ST_SEVERAL;
                end
            end
        end
        return res;
    endfunction

    // The expectation is queued when valid goes up; the item is accepted
    // before any later one, so the order matches the result order.
    task automatic send_request(input logic req, input logic [RANGE_W-1:0] lo,
                                input logic [RANGE_W-1:0] hi, input bit typed,
                                input t_outcome typed_want);
        t_outcome want;
        if (stall_en && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        want = predict_outcome(req, int'(lo), int'(hi));
        if (typed)
            want = typed_want;
        pending_outcomes = {pending_outcomes, want};
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= req;
        req_ch.range_low  <= lo;
        req_ch.range_high <= hi;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic drain_results();
        while (pending_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    initial begin
        rsp_ch.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (stall_en && $urandom_range(0, 7) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                $error("result item with nothing expected: max_gap %0d status %0d",
                       rsp_ch.max_gap, rsp_ch.status);
            end else begin
                want = pending_outcomes.pop_front();
                if (rsp_ch.max_gap !== want.gap) begin
                    mismatches++;
                    $error("max_gap expected %0d actual %0d", want.gap, rsp_ch.max_gap);
                end
                if (rsp_ch.status !== want.status) begin
                    mismatches++;
                    $error("status expected %0d actual %0d", want.status, rsp_ch.status);
                end
            end
        end
    end

    initial begin
        int                 phase_limits [NUM_PHASES];
        int                 phase_items  [NUM_PHASES];
        int                 ph;
        int                 k;
        int                 pick;
        int                 top;
        int                 span;
        int                 a;
        logic               req;
        logic [RANGE_W-1:0] lo;
        logic [RANGE_W-1:0] hi;

        mismatches  = 0;
        sieve_built = 1'b0;
        sieve_top   = 0;
        cfg_limit   = 65535;
        stall_en    = 1'b1;

        i_rst_n           <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= REQ_BUILD;
        req_ch.range_low  <= '0;
        req_ch.range_high <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.limit      <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < NUM_PROBES; k++)
            send_request(PROBES[k].req, PROBES[k].lo, PROBES[k].hi,
                         PROBES[k].typed, PROBES[k].want);
        req_ch.valid <= 1'b0;

        // Limits below two cover at most 0 and 1; the full-range build comes
        // last so most phases stay cheap.
        phase_limits = '{2, 0, 1, 131, $urandom_range(2, 4000), $urandom_range(2, 4000),
                         $urandom_range(2, 4000), 65535};
        phase_items  = '{40, 15, 15, 60, 80, 80, 80, 100};

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            stall_en = (ph != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);

            cfg_ch.valid <= 1'b1;
            cfg_ch.limit <= LIMIT_W'(phase_limits[ph]);
            do @(posedge i_clk); while (!cfg_ch.ready);
            cfg_ch.valid <= 1'b0;
            cfg_limit = phase_limits[ph];

            // The first few queries of a phase still see the previous build,
            // so the two limit checks disagree there.
            for (k = 0; k < phase_items[ph]; k++) begin
                pick = $urandom_range(0, 99);
                top  = (cfg_limit < sieve_top) ? cfg_limit : sieve_top;
                lo   = LIMIT_W'($urandom);
                hi   = LIMIT_W'($urandom);
                if (k == 3 || (k > 3 && pick < 4 && cfg_limit <= 4096)) begin
                    req = REQ_BUILD;
                end else if (pick < 12) begin
                    req = REQ_QUERY;
                end else if (pick < 18) begin
                    req = REQ_QUERY;
                    a   = $urandom_range(1, 65535);
                    lo  = RANGE_W'(a);
                    hi  = RANGE_W'($urandom_range(0, a - 1));
                end else begin
                    req  = REQ_QUERY;
                    lo   = RANGE_W'($urandom_range(0, top));
                    a    = $urandom_range(0, 19);
                    if (a < 14)
                        span = $urandom_range(0, 40);
                    else if (a < 19)
                        span = $urandom_range(0, 600);
                    else
                        span = $urandom_range(0, top);
                    span = int'(lo) + span;
                    hi   = RANGE_W'((span > top) ? top : span);
                end
                send_request(req, lo, hi, 1'b0, '0);
            end
            req_ch.valid <= 1'b0;
        end

        drain_results();
        if (pending_outcomes.size() != 0) begin
            mismatches++;
            $error("%0d expected result items never arrived", pending_outcomes.size());
        end
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
